// ===== sv/dat_pkg.sv =====
package dat_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ACC_W     = 34;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_QUERY  = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_ADDED   = 3'd0,
        K_FULL    = 3'd1,
        K_CANCEL  = 3'd2,
        K_QUERY   = 3'd3,
        K_FIRED   = 3'd4,
        K_TICK    = 3'd5,
        K_SPARE6  = 3'd6,
        K_SPARE7  = 3'd7
    } kind_t;

    localparam logic [1:0] REG_ENABLE = 2'd0;

    typedef struct packed {
        logic [31:0]      handle;
        logic [31:0]      delay;
        logic [ACC_W-1:0] accum;
        logic [31:0]      stamp;
        logic             frame_mode;
        logic             rpt;
        logic             dead;
    } entry_t;

    typedef struct packed {
        entry_t nxt;
        logic   fire;
    } upd_t;

endpackage

// ===== sv/dat_if.sv =====
interface dat_req_if;
    import dat_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] handle;
    logic [31:0] delay_amount;
    logic        repeat_req;
    logic        count_frames;
    logic [31:0] now_time;
    modport source (output valid, opcode, handle, delay_amount, repeat_req, count_frames,
                    now_time, input ready);
    modport sink (input valid, opcode, handle, delay_amount, repeat_req, count_frames,
                  now_time, output ready);
endinterface

interface dat_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] result_handle;
    logic        live;
    logic        last;
    modport source (output valid, kind, result_handle, live, last, input ready);
    modport sink (input valid, kind, result_handle, live, last, output ready);
endinterface

// ===== sv/dat_mem.sv =====
module dat_mem #(
    parameter int DEPTH = dat_pkg::DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output dat_pkg::entry_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  dat_pkg::entry_t wr_data
);
    import dat_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== sv/dat_upd.sv =====
module dat_upd (
    input  dat_pkg::entry_t cur,
    input  logic [31:0]     now,
    output dat_pkg::upd_t   upd
);
    import dat_pkg::*;

    localparam logic [ACC_W:0] ACC_MAX = {1'b0, {ACC_W{1'b1}}};

    logic [31:0]    diff;
    logic [ACC_W:0] inc;
    logic [ACC_W:0] sum;
    logic [ACC_W:0] sat;
    logic           hit;

    always_comb
    begin
        diff = now - cur.stamp;
        inc  = cur.frame_mode ? {{ACC_W{1'b0}}, 1'b1} : {{(ACC_W - 31){1'b0}}, diff};
        sum  = {1'b0, cur.accum} + inc;
        sat  = (sum > ACC_MAX) ? ACC_MAX : sum;
        hit  = sat >= {{(ACC_W - 31){1'b0}}, cur.delay};
        upd.nxt = cur;
        upd.fire = hit;
        if (!cur.frame_mode)
        begin
            upd.nxt.stamp = now;
        end
        if (hit)
        begin
            // frame mode clears, time mode keeps the excess
            upd.nxt.accum = cur.frame_mode ? '0 :
                            ACC_W'(sat - {{(ACC_W - 31){1'b0}}, cur.delay});
            upd.nxt.dead = !cur.rpt;
        end
        else
        begin
            upd.nxt.accum = ACC_W'(sat);
        end
    end
endmodule

// ===== sv/delayed_action_timer_table.sv =====
// Timer table: keeps up to DEPTH timers in insertion order in one
// synchronous memory (one read port, one write port, registered read).
// Requests arrive on req (valid/ready); results leave on rsp through an
// output register, each flagged last on the final one of its request.
// add    : writes the entry at the tail on acceptance, answers added (with a fresh handle) or full.
// cancel : walks the table, reading then evaluating each entry, marks the first match dead.
// query  : same walk, answers whether a live entry holds the handle.
// tick   : walks all entries, updating each live one, reporting every
//          firing, and writing survivors back compacted. Ends with a
//          tick-done result. While enable is low it skips the walk and
//          only answers tick-done.
// One request is in flight at a time; req.ready rises again once the final
// result has been loaded into the output register.
// A stalled receiver holds the walk: each result waits in the output
// register until taken, and the walk stalls at the next result until then.
// Reset empties the table (count zero), sets the next handle to one and
// clears enable. Memory contents are not cleared; only entries below the
// count are ever read.
module delayed_action_timer_table #(
    parameter int DEPTH = dat_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dat_req_if.sink     req,
    dat_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dat_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_EMIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic          enable_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   next_handle_reg, next_handle_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] w_reg, w_next;
    logic          found_reg, found_next;
    op_t           op_reg;
    logic [31:0]   key_reg;
    logic [31:0]   now_reg;
    logic [31:0]   fire_h_reg, fire_h_next;
    logic          full_reg, full_next;

    logic          out_valid_reg, out_valid_next;
    kind_t         out_kind_reg, out_kind_next;
    logic [31:0]   out_handle_reg, out_handle_next;
    logic          out_live_reg, out_live_next;
    logic          out_last_reg, out_last_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    upd_t          upd;
    logic          accept;
    logic          out_free;
    entry_t        new_entry;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == REG_ENABLE)
        begin
            enable_reg <= pwdata[0];
        end
    end

    dat_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    dat_upd u_upd (
        .cur (rd_data),
        .now (now_reg),
        .upd (upd)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.result_handle = out_handle_reg;
    assign rsp.live      = out_live_reg;
    assign rsp.last      = out_last_reg;

    always_comb
    begin
        new_entry.handle     = next_handle_reg;
        new_entry.delay      = req.delay_amount;
        new_entry.accum      = '0;
        new_entry.stamp      = req.now_time;
        new_entry.frame_mode = req.count_frames;
        new_entry.rpt        = req.repeat_req;
        new_entry.dead       = 1'b0;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        next_handle_next = next_handle_reg;
        idx_next         = idx_reg;
        w_next           = w_reg;
        found_next       = found_reg;
        fire_h_next      = fire_h_reg;
        full_next        = full_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_handle_next  = out_handle_reg;
        out_live_next    = out_live_reg;
        out_last_next    = out_last_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[AW-1:0];
        wr_en            = 1'b0;
        wr_addr          = w_reg[AW-1:0];
        wr_data          = upd.nxt;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    w_next     = '0;
                    found_next = 1'b0;
                    full_next  = count_reg >= DEPTH_C;
                    case (op_t'(req.opcode))
                        OP_ADD:
                        begin
                            // store the new timer at the tail straight away, if there is room
                            wr_en      = count_reg < DEPTH_C;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = new_entry;
                            state_next = S_DONE;
                        end
                        OP_TICK:
                        begin
                            // a disabled tick keeps the count as it is
                            w_next     = enable_reg ? '0 : count_reg;
                            state_next = enable_reg ? S_READ : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EVAL:
            begin
                state_next = S_READ;
                idx_next   = idx_reg + 1'b1;
                case (op_reg)
                    OP_CANCEL:
                    begin
                        if (!found_reg && rd_data.handle == key_reg)
                        begin
                            found_next   = 1'b1;
                            wr_en        = 1'b1;
                            wr_addr      = idx_reg[AW-1:0];
                            wr_data      = rd_data;
                            wr_data.dead = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (rd_data.handle == key_reg && !rd_data.dead)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        // dead entries drop out; survivors move down to w
                        if (!rd_data.dead)
                        begin
                            if (!upd.nxt.dead)
                            begin
                                wr_en  = 1'b1;
                                w_next = w_reg + 1'b1;
                            end
                            if (upd.fire)
                            begin
                                fire_h_next = rd_data.handle;
                                idx_next    = idx_reg;
                                state_next  = S_EMIT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = K_FIRED;
                    out_handle_next = fire_h_reg;
                    out_live_next   = 1'b0;
                    out_last_next   = 1'b0;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = '0;
                    out_live_next   = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (full_reg)
                            begin
                                out_kind_next = K_FULL;
                            end
                            else
                            begin
                                out_kind_next    = K_ADDED;
                                out_handle_next  = next_handle_reg;
                                next_handle_next = next_handle_reg + 32'd1;
                                count_next       = count_reg + 1'b1;
                            end
                        end
                        OP_CANCEL:
                        begin
                            out_kind_next = K_CANCEL;
                        end
                        OP_QUERY:
                        begin
                            out_kind_next = K_QUERY;
                            out_live_next = found_reg;
                        end
                        default:
                        begin
                            out_kind_next = K_TICK;
                            count_next    = w_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            next_handle_reg <= 32'd1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            next_handle_reg <= next_handle_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request and walk payload: hold while the walk runs
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(req.opcode);
            key_reg <= req.handle;
            now_reg <= req.now_time;
        end
        idx_reg        <= idx_next;
        w_reg          <= w_next;
        found_reg      <= found_next;
        fire_h_reg     <= fire_h_next;
        full_reg       <= full_next;
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_live_reg   <= out_live_next;
        out_last_reg   <= out_last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind == K_FIRED |-> !rsp.last)
        else $error("fired result flagged last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("second request taken while one is in flight");

endmodule
